// File: rtl/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define KFTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfts assertion failed");

// Next-cycle implication, idle during reset.
`define KFTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfts assertion failed");

// Next-cycle implication that also watches reset itself.
`define KFTS_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("kfts assertion failed");

`endif

// File: rtl/kfts_pkg.sv
// Shared types, codes and helpers of the two-state Kalman filter unit.
`default_nettype none
package kfts_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 66;
  localparam int DEN_W  = 34;
  localparam int QUO_W  = 33;
  localparam int CNT_W  = 6;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
  localparam logic [1:0] CFG_PROC_NOISE = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE = 2'd2;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_PRED1,
    OP_PRED2,
    OP_PRED3,
    OP_PRED4,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_UPD0,
    OP_UPD1,
    OP_UPD2,
    OP_UPD3,
    OP_UPD4,
    OP_UPD5,
    OP_UPD6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DINIT,
    ST_DIV,
    ST_DEND,
    ST_UPD,
    ST_WAIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(32'sh7fffffff);
    lo = -PROD_W'(33'sh080000000);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/kfts_ctrl.sv
// Sequencer of the filter step: issues one datapath operation per cycle.
`default_nettype none
module kfts_ctrl
  import kfts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = 3'd0;
        if (in_valid) state_next = ST_PRED;
      end
      ST_PRED: begin
        if (cnt == 3'd3) begin
          state_next = ST_DINIT;
          cnt_next   = 3'd0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_DINIT: state_next = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) state_next = ST_DEND;
      end
      ST_DEND: begin
        state_next = ST_UPD;
        cnt_next   = 3'd0;
      end
      ST_UPD: begin
        if (cnt == 3'd6) begin
          state_next = ST_WAIT;
          cnt_next   = 3'd0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_WAIT: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op       = OP_IDLE;
    cmd.out_load = 1'b0;
    in_stall     = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_PRED: begin
        case (cnt)
          3'd0:    cmd.op = OP_PRED1;
          3'd1:    cmd.op = OP_PRED2;
          3'd2:    cmd.op = OP_PRED3;
          default: cmd.op = OP_PRED4;
        endcase
      end
      ST_DINIT: cmd.op = OP_DIV_INIT;
      ST_DIV:   cmd.op = OP_DIV_STEP;
      ST_DEND:  cmd.op = OP_DIV_END;
      ST_UPD: begin
        case (cnt)
          3'd0:    cmd.op = OP_UPD0;
          3'd1:    cmd.op = OP_UPD1;
          3'd2:    cmd.op = OP_UPD2;
          3'd3:    cmd.op = OP_UPD3;
          3'd4:    cmd.op = OP_UPD4;
          3'd5:    cmd.op = OP_UPD5;
          default: cmd.op = OP_UPD6;
        endcase
      end
      ST_WAIT: cmd.out_load = !stat.out_busy;
      default: cmd.op = OP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/kfts_datapath.sv
// Filter state, shared multiplier, two-lane restoring divider and output word.
`default_nettype none
module kfts_datapath
  import kfts_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctl_cmd_t                 cmd,
  output dp_stat_t                      stat,
  input  wire logic [7:0]               time_step,
  input  wire logic [15:0]              process_noise,
  input  wire logic [23:0]              measurement_noise,
  input  wire logic signed [DATA_W-1:0] measurement,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      filtered_position
);

  localparam int NW = DATA_W + FRAC_BITS;
  localparam int HW = NW - QUO_W;
  localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // Filter state and step temporaries
  logic signed [DATA_W-1:0] pos, vel, p00, p01, p10, p11;
  logic signed [DATA_W-1:0] z, xp, m00, m01, m10, m11, e, k0, k1;
  logic signed [PROD_W-1:0] acc, prod, fxr;
  logic signed [DEN_W-1:0]  s;
  logic signed [32:0]       mul_a, mul_b;
  logic [15:0]              tt;
  logic signed [PROD_W-1:0] q_w;

  // Divider lanes
  logic [DEN_W-1:0]  den;
  logic              s_zero;
  logic [CNT_W-1:0]  dcnt;
  logic              ln_neg [2];
  logic              ln_ovf [2];
  logic [DEN_W-1:0]  ln_rem [2];
  logic [QUO_W-1:0]  ln_low [2];
  logic [QUO_W-1:0]  ln_q   [2];
  logic [DEN_W-1:0]  den_c;
  logic              ini_neg [2];
  logic              ini_ovf [2];
  logic [HW-1:0]     ini_hi  [2];
  logic [QUO_W-1:0]  ini_low [2];
  logic [DEN_W-1:0]  stp_rem [2];
  logic              stp_bit [2];
  logic signed [DATA_W-1:0] quo [2];

  assign tt  = 16'(time_step) * 16'(time_step);
  assign q_w = $signed({50'd0, process_noise});
  assign fxr = (prod + HALF) >>> FRAC_BITS;

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LOAD:  begin mul_a = $signed({25'd0, time_step}); mul_b = 33'(vel); end
      OP_PRED1: begin mul_a = $signed({25'd0, time_step}); mul_b = 33'(p01) + 33'(p10); end
      OP_PRED2: begin mul_a = $signed({17'd0, tt});        mul_b = 33'(p11); end
      OP_PRED3: begin mul_a = $signed({25'd0, time_step}); mul_b = 33'(p11); end
      OP_UPD0:  begin mul_a = 33'(k0); mul_b = 33'(e);   end
      OP_UPD1:  begin mul_a = 33'(k1); mul_b = 33'(e);   end
      OP_UPD2:  begin mul_a = 33'(k0); mul_b = 33'(m00); end
      OP_UPD3:  begin mul_a = 33'(k0); mul_b = 33'(m01); end
      OP_UPD4:  begin mul_a = 33'(k1); mul_b = 33'(m00); end
      OP_UPD5:  begin mul_a = 33'(k1); mul_b = 33'(m01); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Divider lane setup and one quotient bit per lane
  always_comb begin
    logic signed [DATA_W-1:0] num;
    logic signed [32:0]       num_w;
    logic [DATA_W-1:0]        mag;
    logic [NW-1:0]            nfull;
    logic [DEN_W:0]           trial;
    logic signed [DEN_W:0]    qs;
    den_c = s[DEN_W-1] ? DEN_W'(-s) : DEN_W'(s);
    for (int i = 0; i < 2; i++) begin
      num        = (i == 0) ? m00 : m10;
      num_w      = 33'(num);
      mag        = num[DATA_W-1] ? DATA_W'(-num_w) : DATA_W'(num_w);
      nfull      = {mag, {FRAC_BITS{1'b0}}};
      ini_hi[i]  = nfull[NW-1:QUO_W];
      ini_low[i] = nfull[QUO_W-1:0];
      ini_neg[i] = num[DATA_W-1] ^ s[DEN_W-1];
      ini_ovf[i] = DEN_W'(ini_hi[i]) >= den_c;
      trial      = {ln_rem[i], ln_low[i][QUO_W-1]};
      stp_bit[i] = trial >= {1'b0, den};
      stp_rem[i] = stp_bit[i] ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      qs         = ln_neg[i] ? -$signed({2'b00, ln_q[i]}) : $signed({2'b00, ln_q[i]});
      if (ln_ovf[i]) begin
        quo[i] = ln_neg[i] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        quo[i] = sat32(PROD_W'(qs));
      end
    end
  end

  // Multiplier product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Step registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:  z <= measurement;
      OP_PRED1: xp <= sat32(PROD_W'(pos) + prod);
      OP_PRED2: acc <= PROD_W'(p00) + q_w + prod;
      OP_PRED3: m00 <= sat32(acc + prod);
      OP_PRED4: begin
        m01 <= sat32(PROD_W'(p01) + prod);
        m10 <= sat32(PROD_W'(p10) + prod);
        m11 <= sat32(PROD_W'(p11) + q_w);
        e   <= sat32(PROD_W'(z) - PROD_W'(xp));
        s   <= DEN_W'(m00) + $signed({10'd0, measurement_noise});
      end
      OP_DIV_INIT: begin
        den    <= den_c;
        s_zero <= (s == '0);
        for (int i = 0; i < 2; i++) begin
          ln_neg[i] <= ini_neg[i];
          ln_ovf[i] <= ini_ovf[i];
          ln_rem[i] <= DEN_W'(ini_hi[i]);
          ln_low[i] <= ini_low[i];
          ln_q[i]   <= '0;
        end
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < 2; i++) begin
          ln_rem[i] <= stp_rem[i];
          ln_low[i] <= {ln_low[i][QUO_W-2:0], 1'b0};
          ln_q[i]   <= {ln_q[i][QUO_W-2:0], stp_bit[i]};
        end
      end
      OP_DIV_END: begin
        k0 <= s_zero ? '0 : quo[0];
        k1 <= s_zero ? '0 : quo[1];
      end
      default: ;
    endcase
  end

  // Divider bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.op == OP_DIV_INIT) begin
      dcnt <= CNT_W'(QUO_W - 1);
    end else if (cmd.op == OP_DIV_STEP && dcnt != '0) begin
      dcnt <= dcnt - CNT_W'(1);
    end
  end

  // Filter state: reset to zero state and identity covariance
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
      p00 <= ONE;
      p01 <= '0;
      p10 <= '0;
      p11 <= ONE;
    end else begin
      case (cmd.op)
        OP_UPD1: pos <= sat32(PROD_W'(xp) + fxr);
        OP_UPD2: vel <= sat32(PROD_W'(vel) + fxr);
        OP_UPD3: p00 <= sat32(PROD_W'(m00) - fxr);
        OP_UPD4: p01 <= sat32(PROD_W'(m01) - fxr);
        OP_UPD5: p10 <= sat32(PROD_W'(m10) - fxr);
        OP_UPD6: p11 <= sat32(PROD_W'(m11) - fxr);
        default: ;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) filtered_position <= pos;
  end

  assign stat.div_done = (dcnt == '0);
  assign stat.out_busy = out_valid && out_stall;

endmodule
`default_nettype wire

// File: rtl/kalman_filter_two_state_unit.sv
// From input word to output word: load, predict (4 steps), a 33-step
// divide with setup and finish, update (7 steps) and an output load.
// Throughput is set by the bit-serial gain divider and the single shared
// multiplier; a new input waits until the last word is through, but is
// taken while the previous result waits. Reset (rst, synchronous) clears
// state to zero, covariance to identity and registers to their defaults.
`default_nettype none
module kalman_filter_two_state_unit
  import kfts_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] measurement,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      filtered_position,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [23:0]              cfg_data
);

  logic [7:0]  time_step;
  logic [15:0] process_noise;
  logic [23:0] measurement_noise;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step         <= 8'd4;
      process_noise     <= 16'd66;
      measurement_noise <= 24'd131072;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIME_STEP:  time_step         <= cfg_data[7:0];
        CFG_PROC_NOISE: process_noise     <= cfg_data[15:0];
        CFG_MEAS_NOISE: measurement_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  kfts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kfts_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .time_step         (time_step),
    .process_noise     (process_noise),
    .measurement_noise (measurement_noise),
    .measurement       (measurement),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .filtered_position (filtered_position)
  );

endmodule
`default_nettype wire

// File: rtl/kfts_checker.sv
// Port-level checks of the filter unit and their bind.
`default_nettype none
`include "assert_macros.svh"
module kfts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        cfg_ready
);

  `KFTS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `KFTS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `KFTS_ASSERT_NXT_RST(a_reset_quiet, rst, !out_valid && !in_stall)
  `KFTS_ASSERT_IMP(a_cfg_open, 1'b1, cfg_ready)

endmodule

bind kalman_filter_two_state_unit kfts_checker u_kfts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the two-state Kalman filter unit: predicts each filtered position and checks it.
`timescale 1ns / 1ps

class kf_scoreboard;
  int unsigned step_no;
  logic [7:0]  cur_time_step;
  logic [15:0] cur_proc_noise;
  logic [23:0] cur_meas_noise;
  logic signed [31:0] pos_est, vel_est;
  logic signed [31:0] cov [4];
  logic signed [31:0] pending [$];
  int errors;

  function new();
    errors = 0;
    cur_time_step = 8'd4;
    cur_proc_noise = 16'd66;
    cur_meas_noise = 24'd131072;
    pos_est = 0;
    vel_est = 0;
    cov[0] = 32'sh10000;
    cov[1] = 0;
    cov[2] = 0;
    cov[3] = 32'sh10000;
  endfunction

  function logic signed [31:0] clamp(input logic signed [127:0] v);
    if (v > 128'sh7fffffff) return 32'sh7fffffff;
    if (v < -128'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // rounded fixed-point product, arithmetic shift floors
  function logic signed [127:0] fmul(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b) + 128'sd32768;
    return p >>> 16;
  endfunction

  function void set_reg(input logic [1:0] idx, input logic [23:0] val);
    case (idx)
      kfts_pkg::CFG_TIME_STEP:  cur_time_step = val[7:0];
      kfts_pkg::CFG_PROC_NOISE: cur_proc_noise = val[15:0];
      kfts_pkg::CFG_MEAS_NOISE: cur_meas_noise = val;
      default: ;
    endcase
  endfunction

  // advance the filter by one measurement word and queue the position
  function void note_input(input logic signed [31:0] z);
    logic signed [127:0] t, q, a, b, c, d, s;
    logic signed [31:0] xp, xv, m00, m01, m10, m11, k0, k1, e;
    t = 128'(cur_time_step);
    q = 128'(cur_proc_noise);
    a = 128'(cov[0]); b = 128'(cov[1]); c = 128'(cov[2]); d = 128'(cov[3]);
    xp = clamp(128'(pos_est) + t * 128'(vel_est));
    xv = vel_est;
    m00 = clamp(a + t * (b + c) + t * t * d + q);
    m01 = clamp(b + t * d);
    m10 = clamp(c + t * d);
    m11 = clamp(d + q);
    s = 128'(m00) + 128'(cur_meas_noise);
    if (s == 0) begin
      k0 = 0;
      k1 = 0;
    end else begin
      k0 = clamp((128'(m00) <<< 16) / s);
      k1 = clamp((128'(m10) <<< 16) / s);
    end
    e = clamp(128'(z) - 128'(xp));
    pos_est = clamp(128'(xp) + fmul(k0, e));
    vel_est = clamp(128'(xv) + fmul(k1, e));
    cov[0] = clamp(128'(m00) - fmul(k0, m00));
    cov[1] = clamp(128'(m01) - fmul(k0, m01));
    cov[2] = clamp(128'(m10) - fmul(k1, m00));
    cov[3] = clamp(128'(m11) - fmul(k1, m01));
    pending.push_back(pos_est);
  endfunction

  function void check_result(input logic signed [31:0] got);
    logic signed [31:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("filtered_position: expected %h, got %h", want, got);
    end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] measurement = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] filtered_position;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [23:0] cfg_data = 0;

  kf_scoreboard board;
  int idle_cycles = 0;
  bit long_hold = 0;
  localparam int WATCHDOG = 20000;

  always #4 clk = ~clk;

  kalman_filter_two_state_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .measurement(measurement),
    .out_valid(out_valid), .out_stall(out_stall), .filtered_position(filtered_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial board = new();

  // score accepted words and watch for a hang
  always @(posedge clk) begin
    bit moved;
    moved = 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        board.note_input(measurement);
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        board.check_result(filtered_position);
        moved = 1;
      end
      if (cfg_valid && cfg_ready) moved = 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("kalman_filter_two_state_unit: mismatch");
        $finish;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // offer one word; valid stays up afterwards so words can follow back to back
  task automatic send_word(input logic signed [31:0] z, input int gap);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    measurement <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_meas();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed(32'($urandom_range(0, 20 << 16))) - 32'sh000a0000;
    endcase
  endfunction

  task automatic random_run(input int n, input int max_gap);
    repeat (n) send_word(rand_meas(), $urandom_range(0, max_gap));
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: extremes at default settings
    send_word(32'sh00000000, 0);
    send_word(32'sh7fffffff, 0);
    send_word(32'sh80000000, 2);
    send_word(32'sh7fffffff, 0);
    send_word(32'shffffffff, 1);
    send_word(32'sh00010000, 0);
    send_word(32'sh55555555, 0);
    send_word(32'shaaaaaaaa, 0);
    drain();
    // zero measurement noise, zero time step and zero process noise
    write_reg(kfts_pkg::CFG_MEAS_NOISE, 24'd0);
    write_reg(kfts_pkg::CFG_TIME_STEP, 24'd0);
    write_reg(kfts_pkg::CFG_PROC_NOISE, 24'd0);
    send_word(32'sh00020000, 0);
    send_word(32'sh80000000, 0);
    send_word(32'sh7fffffff, 0);
    drain();
    // largest settings drive covariance into saturation
    write_reg(kfts_pkg::CFG_TIME_STEP, 24'd255);
    write_reg(kfts_pkg::CFG_PROC_NOISE, 24'hffff);
    write_reg(kfts_pkg::CFG_MEAS_NOISE, 24'hffffff);
    write_reg(2'd3, 24'h123456);
    repeat (8) send_word(rand_meas(), 0);
    drain();
    // fill up while the receiver holds off
    write_reg(kfts_pkg::CFG_TIME_STEP, 24'd1);
    write_reg(kfts_pkg::CFG_PROC_NOISE, 24'd66);
    write_reg(kfts_pkg::CFG_MEAS_NOISE, 24'd1);
    long_hold = 1;
    random_run(6, 0);
    drain();
    // random phases with random settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(kfts_pkg::CFG_TIME_STEP, 24'($urandom_range(0, 255)));
      write_reg(kfts_pkg::CFG_PROC_NOISE, 24'($urandom_range(0, 65535)));
      write_reg(kfts_pkg::CFG_MEAS_NOISE, 24'($urandom_range(1, 24'hffffff)));
      random_run(25, (ph % 3 == 0) ? 0 : 19);
      drain();
    end
    ref_phase();
  end

  // default-like settings keep the filter out of saturation for a long stretch
  task automatic ref_phase();
    write_reg(kfts_pkg::CFG_TIME_STEP, 24'd4);
    write_reg(kfts_pkg::CFG_PROC_NOISE, 24'd66);
    write_reg(kfts_pkg::CFG_MEAS_NOISE, 24'd131072);
    random_run(175, 19);
    drain();
    if (board.errors == 0) begin
      $display("kalman_filter_two_state_unit: match");
    end else begin
      $display("kalman_filter_two_state_unit: mismatch");
    end
    $finish;
  endtask
endmodule
